// File: hdl/ofdm_frame_assembler_core_defines.svh
// Assertion macros for the OFDM frame assembler core.
// Needs clk and rst in scope at the point of use; no other dependencies.
`ifndef OFDM_FRAME_ASSEMBLER_CORE_DEFINES_SVH
`define OFDM_FRAME_ASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define OFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define OFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ofa_pkg.sv
// Shared types, constants and the microcode table of the OFDM frame assembler.
// No dependencies.
package ofa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Q1.14 reference symbol, +0.7 and -0.7
  localparam logic [SAMPLE_BITS-1:0] REF_POS = 16'd11469;
  localparam logic [SAMPLE_BITS-1:0] REF_NEG = 16'd54067;

  // register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_FFT_SIZE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OCCUPIED     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_REP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PILOT_REP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_BLOCKS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_REP     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_REP  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGN_PATTERN = 3'd7;

  typedef enum logic [2:0] {
    PH_COLLECT,
    PH_PREAMBLE,
    PH_PILOT,
    PH_DATA,
    PH_SILENCE
  } phase_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [6:0]  eff_fft;
    logic [6:0]  eff_occ;
    logic [5:0]  pad;
    logic [4:0]  eff_blocks;
    logic [3:0]  pre_reps;
    logic [3:0]  pil_reps;
    logic [3:0]  data_reps;
    logic [3:0]  sil_reps;
    logic [63:0] sign_pattern;
  } cfg_t;

  // microcode
  typedef logic [2:0] ustep_t;
  localparam ustep_t STEP_CALC   = 3'd0;
  localparam ustep_t STEP_BRANCH = 3'd1;
  localparam ustep_t STEP_PUSH   = 3'd2;
  localparam ustep_t STEP_READ   = 3'd3;
  localparam ustep_t STEP_EMIT   = 3'd4;

  typedef enum logic [1:0] {
    SEQ_GOTO,
    SEQ_DISPATCH,
    SEQ_DONE
  } seq_op_t;

  typedef struct packed {
    logic calc;
    logic push;
    logic read;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    ctrl_t   ctrl;
    seq_op_t seq;
    ustep_t  target;
  } uword_t;

  typedef struct packed {
    logic is_pull;
    logic collecting;
    logic frame_full;
  } stat_t;

  function automatic uword_t ucode_word(input ustep_t s);
    uword_t w;
    w = '0;
    w.seq = SEQ_DONE;
    unique case (s)
      STEP_CALC: begin
        w.ctrl.calc = 1'b1;
        w.seq       = SEQ_GOTO;
        w.target    = STEP_BRANCH;
      end
      STEP_BRANCH: begin
        w.seq = SEQ_DISPATCH;
      end
      STEP_PUSH: begin
        w.ctrl.push = 1'b1;
      end
      STEP_READ: begin
        w.ctrl.read = 1'b1;
        w.seq       = SEQ_GOTO;
        w.target    = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/ofa_config.sv
// Configuration registers and clamping of the OFDM frame assembler.
// Depends on ofa_pkg.
module ofa_config #(
  parameter int FFT_MAX    = 64,
  parameter int BLOCKS_MAX = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [ofa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ofa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ofa_pkg::cfg_t                      cfg
);
  import ofa_pkg::*;

  logic [6:0]  fft_size;
  logic [6:0]  occupied_count;
  logic [3:0]  preamble_reps;
  logic [3:0]  pilot_reps;
  logic [4:0]  data_blocks;
  logic [3:0]  data_reps;
  logic [3:0]  silence_reps;
  logic [63:0] sign_pattern;

  logic [6:0] fft_c;
  logic [6:0] occ_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      fft_size       <= 7'd64;
      occupied_count <= 7'd48;
      preamble_reps  <= 4'd2;
      pilot_reps     <= 4'd1;
      data_blocks    <= 5'd4;
      data_reps      <= 4'd1;
      silence_reps   <= 4'd1;
      sign_pattern   <= '0;
    end else if (wr_en) begin
      unique case (cfg_index)
        REG_FFT_SIZE:     fft_size       <= cfg_data[6:0];
        REG_OCCUPIED:     occupied_count <= cfg_data[6:0];
        REG_PREAMBLE_REP: preamble_reps  <= cfg_data[3:0];
        REG_PILOT_REP:    pilot_reps     <= cfg_data[3:0];
        REG_DATA_BLOCKS:  data_blocks    <= cfg_data[4:0];
        REG_DATA_REP:     data_reps      <= cfg_data[3:0];
        REG_SILENCE_REP:  silence_reps   <= cfg_data[3:0];
        REG_SIGN_PATTERN: sign_pattern   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the legal ranges
  always_comb begin
    fft_c = (fft_size < 7'd2) ? 7'd2 :
            (32'(fft_size) > FFT_MAX) ? 7'(FFT_MAX) : fft_size;
    occ_c = (occupied_count < 7'd1) ? 7'd1 :
            (occupied_count > fft_c) ? fft_c : occupied_count;
    cfg.eff_fft      = fft_c;
    cfg.eff_occ      = occ_c;
    cfg.pad          = 6'((fft_c - occ_c) >> 1);
    cfg.eff_blocks   = (data_blocks < 5'd1) ? 5'd1 :
                       (32'(data_blocks) > BLOCKS_MAX) ? 5'(BLOCKS_MAX) : data_blocks;
    cfg.pre_reps     = (preamble_reps == 4'd0) ? 4'd1 : preamble_reps;
    cfg.pil_reps     = (pilot_reps == 4'd0) ? 4'd1 : pilot_reps;
    cfg.data_reps    = data_reps;
    cfg.sil_reps     = silence_reps;
    cfg.sign_pattern = sign_pattern;
  end

endmodule

// File: hdl/ofa_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on ofa_pkg (microcode table and control types).
module ofa_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ofa_pkg::stat_t stat,
  output logic           busy,
  output ofa_pkg::ctrl_t ctrl
);
  import ofa_pkg::*;

  ustep_t step;
  ustep_t step_next;
  logic   busy_next;
  uword_t uword;

  assign uword = ucode_word(step);
  assign ctrl  = busy ? uword.ctrl : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_CALC;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        step_next = STEP_CALC;
      end
    end else begin
      unique case (uword.seq)
        SEQ_GOTO: step_next = uword.target;
        SEQ_DISPATCH: begin
          if (!stat.is_pull && !stat.collecting) begin
            busy_next = 1'b0;            // push during readout
          end else if (!stat.is_pull) begin
            step_next = STEP_PUSH;
          end else if (stat.collecting && !stat.frame_full) begin
            busy_next = 1'b0;            // pull too early
          end else begin
            step_next = STEP_READ;
          end
        end
        default: busy_next = 1'b0;
      endcase
    end
  end

endmodule

// File: hdl/ofa_datapath.sv
// Datapath: sample store, frame counters and output bin formation.
// Depends on ofa_pkg; driven by ofa_sequencer control words.
module ofa_datapath #(
  parameter int FFT_MAX    = 64,
  parameter int BLOCKS_MAX = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic                                   command,
  input  logic signed [ofa_pkg::SAMPLE_BITS-1:0] sample_re,
  input  logic signed [ofa_pkg::SAMPLE_BITS-1:0] sample_im,
  input  ofa_pkg::cfg_t                          cfg,
  input  ofa_pkg::ctrl_t                         ctrl,
  output ofa_pkg::stat_t                         stat,
  output logic                                   done,
  output logic signed [ofa_pkg::SAMPLE_BITS-1:0] out_re,
  output logic signed [ofa_pkg::SAMPLE_BITS-1:0] out_im,
  output logic                                   vector_last,
  output logic                                   frame_last,
  output logic                                   frame_silent
);
  import ofa_pkg::*;

  localparam int DEPTH  = BLOCKS_MAX * FFT_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int BIN_W  = $clog2(FFT_MAX);
  localparam int BLK_W  = $clog2(BLOCKS_MAX + 1);
  localparam int PB_W   = BLK_W + 7;

  phase_t             phase;
  logic [3:0]         rep_counter;
  logic [BLK_W-1:0]   block_counter;
  logic [BIN_W-1:0]   bin_counter;
  logic [CNT_W-1:0]   load_counter;
  logic               first_vector_nonzero;

  logic                   cmd_q;
  logic [SAMPLE_BITS-1:0] re_q;
  logic [SAMPLE_BITS-1:0] im_q;

  logic [CNT_W-1:0]  total;
  logic [ADDR_W-1:0] base;
  logic [11:0]       total_prod;
  logic [PB_W-1:0]   base_prod;

  logic [2*SAMPLE_BITS-1:0] mem [DEPTH];
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mem_we;

  // bin decode
  logic [6:0]             bin_ext;
  logic [6:0]             hi_edge;
  logic [6:0]             j;
  logic                   in_band;
  logic [5:0]             sym_idx;
  logic [SAMPLE_BITS-1:0] ref_val;
  logic [SAMPLE_BITS-1:0] re_d;
  logic [SAMPLE_BITS-1:0] im_d;

  // advance
  logic             vlast;
  logic             flast;
  logic [4:0]       rep_inc;
  logic [BLK_W-1:0] blk_inc;
  phase_t           phase_next;
  logic [3:0]       rep_next;
  logic [BLK_W-1:0] blk_next;
  logic [BIN_W-1:0] bin_next;

  assign total_prod = 12'(cfg.eff_blocks) * 12'(cfg.eff_occ);
  assign base_prod  = PB_W'(block_counter) * PB_W'(cfg.eff_occ);
  assign rd_addr    = base + ADDR_W'(bin_counter) - ADDR_W'(cfg.pad);
  assign mem_we     = ctrl.push && (load_counter < total);

  assign stat.is_pull    = cmd_q;
  assign stat.collecting = (phase == PH_COLLECT);
  assign stat.frame_full = (load_counter >= total);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      re_q  <= sample_re;
      im_q  <= sample_im;
    end
    if (ctrl.calc) begin
      total <= CNT_W'(total_prod);
      base  <= ADDR_W'(base_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[load_counter[ADDR_W-1:0]] <= {re_q, im_q};
    end
    if (ctrl.read) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    bin_ext = 7'(bin_counter);
    hi_edge = cfg.eff_fft - 7'(cfg.pad);
    j       = bin_ext - 7'(cfg.pad);
    in_band = first_vector_nonzero && (bin_ext >= 7'(cfg.pad)) && (bin_ext < hi_edge);
    sym_idx = (phase == PH_PILOT) ? j[5:0] : j[6:1];
    ref_val = cfg.sign_pattern[sym_idx] ? REF_NEG : REF_POS;
    re_d    = '0;
    im_d    = '0;
    if (in_band && ((phase == PH_PILOT) || ((phase == PH_PREAMBLE) && !j[0]))) begin
      re_d = ref_val;
      im_d = ref_val;
    end else if (in_band && (phase == PH_DATA) && (j < cfg.eff_occ)) begin
      re_d = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
      im_d = rd_data[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    vlast      = (bin_ext + 7'd1) >= cfg.eff_fft;
    rep_inc    = {1'b0, rep_counter} + 5'd1;
    blk_inc    = block_counter + 1'b1;
    flast      = 1'b0;
    phase_next = phase;
    rep_next   = rep_counter;
    blk_next   = block_counter;
    bin_next   = bin_counter + 1'b1;
    if (vlast) begin
      bin_next = '0;
      unique case (phase)
        PH_PREAMBLE: begin
          rep_next = rep_inc[3:0];
          if (rep_inc >= {1'b0, cfg.pre_reps}) begin
            rep_next   = '0;
            phase_next = PH_PILOT;
          end
        end
        PH_PILOT: begin
          rep_next = rep_inc[3:0];
          if (rep_inc >= {1'b0, cfg.pil_reps}) begin
            rep_next = '0;
            blk_next = '0;
            if (cfg.data_reps != 4'd0) begin
              phase_next = PH_DATA;
            end else if (cfg.sil_reps != 4'd0) begin
              phase_next = PH_SILENCE;
            end else begin
              flast = 1'b1;
            end
          end
        end
        PH_DATA: begin
          blk_next = blk_inc;
          if (8'(blk_inc) >= 8'(cfg.eff_blocks)) begin
            blk_next = '0;
            rep_next = rep_inc[3:0];
            if (rep_inc >= {1'b0, cfg.data_reps}) begin
              rep_next = '0;
              if (cfg.sil_reps != 4'd0) begin
                phase_next = PH_SILENCE;
              end else begin
                flast = 1'b1;
              end
            end
          end
        end
        default: begin
          rep_next = rep_inc[3:0];
          flast    = (rep_inc >= {1'b0, cfg.sil_reps});
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_COLLECT;
      rep_counter          <= '0;
      block_counter        <= '0;
      bin_counter          <= '0;
      load_counter         <= '0;
      first_vector_nonzero <= 1'b0;
      done                 <= 1'b0;
    end else begin
      done <= ctrl.emit;
      if (mem_we) begin
        load_counter <= load_counter + 1'b1;
        if ((load_counter < CNT_W'(cfg.eff_occ)) && ((re_q != '0) || (im_q != '0))) begin
          first_vector_nonzero <= 1'b1;
        end
      end
      if (ctrl.read && (phase == PH_COLLECT)) begin
        phase         <= PH_PREAMBLE;
        rep_counter   <= '0;
        block_counter <= '0;
        bin_counter   <= '0;
      end
      if (ctrl.emit) begin
        if (flast) begin
          phase                <= PH_COLLECT;
          rep_counter          <= '0;
          block_counter        <= '0;
          bin_counter          <= '0;
          load_counter         <= '0;
          first_vector_nonzero <= 1'b0;
        end else begin
          phase         <= phase_next;
          rep_counter   <= rep_next;
          block_counter <= blk_next;
          bin_counter   <= bin_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_re       <= re_d;
      out_im       <= im_d;
      vector_last  <= vlast;
      frame_last   <= flast;
      frame_silent <= !first_vector_nonzero;
    end
  end

endmodule

// File: hdl/ofdm_frame_assembler_core.sv
// OFDM frame assembler top level; holds config port, sequencer and datapath.
// Depends on ofa_pkg, ofa_config, ofa_sequencer, ofa_datapath and the defines header.
// A pull's bin is on done, registered after the EMIT step; no back-pressure.
// A new command is taken only while busy is low, after the last one has ended;
//   its length follows the steps CALC, BRANCH, then PUSH or READ and EMIT.
// Reset (rst, synchronous): counters cleared, collecting, registers at defaults.
`include "ofdm_frame_assembler_core_defines.svh"

module ofdm_frame_assembler_core #(
  parameter int FFT_MAX    = 64,
  parameter int BLOCKS_MAX = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   command,
  input  logic signed [ofa_pkg::SAMPLE_BITS-1:0] sample_re,
  input  logic signed [ofa_pkg::SAMPLE_BITS-1:0] sample_im,
  // result strobe, no back-pressure
  output logic                                   done,
  output logic signed [ofa_pkg::SAMPLE_BITS-1:0] out_re,
  output logic signed [ofa_pkg::SAMPLE_BITS-1:0] out_im,
  output logic                                   vector_last,
  output logic                                   frame_last,
  output logic                                   frame_silent,
  // register write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ofa_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ofa_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import ofa_pkg::*;

  // A transfer on the command channel takes start with busy low. The
  // sequencer then walks the microcode:
  //   CALC   - register total sample count and data-block base address
  //   BRANCH - dispatch on command and phase
  //   PUSH   - store one sample (ignored once the collection is full)
  //   READ   - start readout if still collecting, read the store
  //   EMIT   - form the bin, advance bin/vector/block/rep counters
  // A pull in the collect phase before the store is full, or a push during
  // readout, ends at BRANCH with no result.

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;
  logic  accept;
  logic  cfg_wr;

  assign accept    = start && !busy;
  // registers only change between commands
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  ofa_config #(
    .FFT_MAX   (FFT_MAX),
    .BLOCKS_MAX(BLOCKS_MAX)
  ) u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  ofa_sequencer u_sequencer (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .ctrl (ctrl)
  );

  ofa_datapath #(
    .FFT_MAX   (FFT_MAX),
    .BLOCKS_MAX(BLOCKS_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .sample_re   (sample_re),
    .sample_im   (sample_im),
    .cfg         (cfg),
    .ctrl        (ctrl),
    .stat        (stat),
    .done        (done),
    .out_re      (out_re),
    .out_im      (out_im),
    .vector_last (vector_last),
    .frame_last  (frame_last),
    .frame_silent(frame_silent)
  );

  // a result always closes a command, and the frame ends on a vector end
  `OFA_ASSERT_NOW(a_done_idle, done, !busy, "result while command still running")
  `OFA_ASSERT_NOW(a_done_after_cmd, done, $past(busy), "result without a running command")
  `OFA_ASSERT_NOW(a_frame_on_vector, done && frame_last, vector_last, "frame end mid-vector")
  `OFA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not start")

endmodule
